FILE: rtl/dmsc_pkg.sv
// Shared types and constants of the RGGB bilinear demosaic.
package dmsc_pkg;

   localparam int unsigned CSR_INDEX_W = 1;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1440;
   localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;

   // Position of a request inside the frame, decoded once at acceptance
   typedef struct packed {
      logic prev_row;    // row >= 1
      logic prev2_row;   // row >= 2
      logic last_row;
      logic prev_col;    // col >= 1
      logic prev2_col;   // col >= 2
      logic last_col;
   } pos_flags_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
      logic       frame_done;
   } result_type;

endpackage

FILE: rtl/dmsc_line_store.sv
// Three-row line store: one synchronous byte memory per row slot.
module dmsc_line_store #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned AW    = 11
) (
   input  logic                clock,
   input  logic                access,
   input  logic [1:0]          wr_slot,
   input  logic [AW-1:0]       addr,
   input  logic [7:0]          wr_data,
   output logic [2:0][7:0]     rd_data
);

   for (genvar b = 0; b < 3; b++) begin : g_bank
      logic [7:0] line_mem [DEPTH];
      logic [7:0] rd_ff;

      // Write the new sample into its own slot; every slot reads the same column.
      always_ff @(posedge clock) begin
         if (access && (wr_slot == 2'(b))) begin
            line_mem[addr] <= wr_data;
         end
         if (access) begin
            rd_ff <= line_mem[addr];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

FILE: rtl/dmsc_window.sv
// Window stage: column history, edge clamping, result sequencing and interpolation.
module dmsc_window #(
   parameter int unsigned CW = 11,
   parameter int unsigned RW = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [CW-1:0]          ld_col,
   input  logic [RW-1:0]          ld_row,
   input  logic [1:0]             ld_slot,
   input  logic [7:0]             ld_pixel,
   input  dmsc_pkg::pos_flags_type ld_flags,
   input  logic [2:0][7:0]        rd_data,
   input  logic                   out_free,
   output logic                   take,
   output logic                   res_valid,
   output logic [CW-1:0]          res_col,
   output logic [RW-1:0]          res_row,
   output dmsc_pkg::result_type   res
);

   // Raw column: u = row j-2, m = row j-1, d = row j
   typedef struct packed {
      logic [7:0] u;
      logic [7:0] m;
      logic [7:0] d;
   } col_type;

   logic                    s1_valid_ff, s1_valid_in;
   logic [CW-1:0]           col_ff;
   logic [RW-1:0]           row_ff;
   logic [1:0]              slot_ff;
   logic [7:0]              pixel_ff;
   dmsc_pkg::pos_flags_type flags_ff;
   logic                    row_sel_ff, row_sel_in;
   logic                    col_sel_ff, col_sel_in;
   col_type                 cola_ff, colb_ff;

   col_type cur_col, lraw, craw, rraw, lwin, cwin, rwin;
   logic    has_results, can_col_adv, can_row_adv, last_sub, done;
   logic    up_ok, even_row, even_col;

   function automatic col_type vclamp(input col_type raw, input logic cur_row,
                                      input logic up_ok_i);
      col_type v;
      if (cur_row) begin
         v.u = up_ok_i ? raw.m : raw.d;
         v.m = raw.d;
         v.d = raw.d;
      end else begin
         v.u = up_ok_i ? raw.u : raw.m;
         v.m = raw.m;
         v.d = raw.d;
      end
      return v;
   endfunction

   function automatic dmsc_pkg::result_type interp(input col_type l, input col_type c,
                                                   input col_type r, input logic er,
                                                   input logic ec);
      dmsc_pkg::result_type o;
      logic [9:0] cross_sum;
      logic [9:0] diag;
      logic [8:0] horiz;
      logic [8:0] vert;
      cross_sum = 10'(l.m) + 10'(r.m) + 10'(c.u) + 10'(c.d);
      diag  = 10'(l.u) + 10'(r.u) + 10'(l.d) + 10'(r.d);
      horiz = 9'(l.m) + 9'(r.m);
      vert  = 9'(c.u) + 9'(c.d);
      o = '0;
      if (er && ec) begin
         o.red = c.m;        o.green = cross_sum[9:2]; o.blue = diag[9:2];
      end else if (er) begin
         o.red = horiz[8:1]; o.green = c.m;            o.blue = vert[8:1];
      end else if (ec) begin
         o.red = vert[8:1];  o.green = c.m;            o.blue = horiz[8:1];
      end else begin
         o.red = diag[9:2];  o.green = cross_sum[9:2]; o.blue = c.m;
      end
      return o;
   endfunction

   // Pick the two earlier rows out of the slot ring
   always_comb begin
      cur_col.d = pixel_ff;
      case (slot_ff)
         2'd0: begin cur_col.u = rd_data[1]; cur_col.m = rd_data[2]; end
         2'd1: begin cur_col.u = rd_data[2]; cur_col.m = rd_data[0]; end
         2'd2: begin cur_col.u = rd_data[0]; cur_col.m = rd_data[1]; end
         default: begin cur_col.u = rd_data[1]; cur_col.m = rd_data[2]; end
      endcase
   end

   assign has_results = (flags_ff.prev_row || flags_ff.last_row) &&
                        (flags_ff.prev_col || flags_ff.last_col);
   assign can_col_adv = !col_sel_ff && flags_ff.last_col;
   assign can_row_adv = !row_sel_ff && flags_ff.last_row;
   assign last_sub    = !can_col_adv && !can_row_adv;
   assign res_valid   = s1_valid_ff && has_results && out_free;
   assign done        = s1_valid_ff && (!has_results || (out_free && last_sub));
   assign take        = !s1_valid_ff || done;

   // Horizontal clamp, then vertical clamp of each window column
   always_comb begin
      if (col_sel_ff) begin
         lraw = flags_ff.prev_col ? colb_ff : cur_col;
         craw = cur_col;
      end else begin
         lraw = flags_ff.prev2_col ? cola_ff : colb_ff;
         craw = colb_ff;
      end
      rraw  = cur_col;
      up_ok = row_sel_ff ? flags_ff.prev_row : flags_ff.prev2_row;
      lwin  = vclamp(lraw, row_sel_ff, up_ok);
      cwin  = vclamp(craw, row_sel_ff, up_ok);
      rwin  = vclamp(rraw, row_sel_ff, up_ok);
      even_row = !(row_ff[0] ^ !row_sel_ff);
      even_col = !(col_ff[0] ^ !col_sel_ff);
      res = interp(lwin, cwin, rwin, even_row, even_col);
      res.run_last   = last_sub;
      res.frame_done = col_sel_ff && flags_ff.last_col && row_sel_ff && flags_ff.last_row;
      res_col = col_sel_ff ? col_ff : col_ff - CW'(1);
      res_row = row_sel_ff ? row_ff : row_ff - RW'(1);
   end

   // Walk the results of one request: along the row first, then to the next row
   always_comb begin
      s1_valid_in = s1_valid_ff;
      row_sel_in  = row_sel_ff;
      col_sel_in  = col_sel_ff;
      if (load) begin
         s1_valid_in = 1'b1;
         row_sel_in  = !ld_flags.prev_row;
         col_sel_in  = !ld_flags.prev_col;
      end else begin
         if (done) begin
            s1_valid_in = 1'b0;
         end
         if (res_valid && !last_sub) begin
            if (can_col_adv) begin
               col_sel_in = 1'b1;
            end else begin
               row_sel_in = 1'b1;
               col_sel_in = !flags_ff.prev_col;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         row_sel_ff  <= 1'b0;
         col_sel_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         row_sel_ff  <= row_sel_in;
         col_sel_ff  <= col_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff   <= ld_col;
         row_ff   <= ld_row;
         slot_ff  <= ld_slot;
         pixel_ff <= ld_pixel;
         flags_ff <= ld_flags;
      end
      if (done) begin
         colb_ff <= cur_col;
         cola_ff <= colb_ff;
      end
   end

endmodule

FILE: rtl/bayer_rggb_bilinear_demosaic.sv
// Top level of the RGGB Bayer bilinear demosaic.
// Raw 8-bit RGGB samples enter in raster order on the req_ channel, one per
// request, and RGB pixels leave on the rsp_ channel with their column and row.
// A request at (i,j) releases every pixel whose 3x3 window is then complete:
// pixel (i-1,j-1), plus column i at the end of a row and row j in the last
// row, in row-then-column order; run_last marks the last pixel of a request
// and frame_done the bottom-right pixel. Frame edges are clamped. Throughput
// is one request per clock inside the frame while rsp_ready is high; the
// single result port sets the rest: a request holds the input until every
// pixel it releases (two at most at the end of a row or in the last row, four
// for the bottom-right request) has entered the output register. Each result
// is computed from the line-store read register, then held in the output register.
// The line store is three banks of MAX_WIDTH bytes, one per row slot, read once
// and written once per request; it needs no clearing after reset. csr_ writes
// of frame_width (index 0) or frame_height (index 1) restart the frame; a size
// of 0 acts as 1, and sizes above MAX_WIDTH or MAX_HEIGHT are limited to them.
// Write configuration only while idle.
module bayer_rggb_bilinear_demosaic #(
   parameter int unsigned MAX_WIDTH  = 2048,
   parameter int unsigned MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_raw_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [10:0]                         rsp_out_col,
   output logic [10:0]                         rsp_out_row,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [11:0]                         csr_wdata
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam logic [13:0] LIMIT_W = 14'(MAX_WIDTH);
   localparam logic [13:0] LIMIT_H = 14'(MAX_HEIGHT);

   // Last index in use for a programmed size
   function automatic logic [13:0] last_index(input logic [11:0] size, input logic [13:0] limit);
      logic [13:0] s;
      s = {2'b00, size};
      if (s == 14'd0) begin
         return 14'd0;
      end else if (s > limit) begin
         return limit - 14'd1;
      end else begin
         return s - 14'd1;
      end
   endfunction

   localparam logic [13:0] LAST_COL_RST = last_index(dmsc_pkg::FRAME_WIDTH_RST, LIMIT_W);
   localparam logic [13:0] LAST_ROW_RST = last_index(dmsc_pkg::FRAME_HEIGHT_RST, LIMIT_H);

   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [1:0]    slot_ff, slot_in;
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [13:0]   wr_last_col, wr_last_row;

   logic                    accept, csr_write, at_last_col, at_last_row, out_free;
   dmsc_pkg::pos_flags_type ld_flags;
   logic [2:0][7:0]         rd_data;
   logic                    res_valid;
   logic [CW-1:0]           res_col;
   logic [RW-1:0]           res_row;
   dmsc_pkg::result_type    res;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_col_ff;
   logic [RW-1:0]           rsp_row_ff;
   dmsc_pkg::result_type    rsp_res_ff;
   logic [CW+10:0]          col_ext;
   logic [RW+10:0]          row_ext;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign accept      = req_valid && req_ready;
   assign at_last_col = col_count_ff == last_col_ff;
   assign at_last_row = row_count_ff == last_row_ff;
   assign wr_last_col = last_index(csr_wdata, LIMIT_W);
   assign wr_last_row = last_index(csr_wdata, LIMIT_H);

   // Frame geometry: any register write restarts the frame
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_write) begin
         case (csr_index)
            dmsc_pkg::REG_FRAME_WIDTH:  last_col_in = wr_last_col[CW-1:0];
            dmsc_pkg::REG_FRAME_HEIGHT: last_row_in = wr_last_row[RW-1:0];
            default: ;
         endcase
      end
   end

   // Advance the raster position; the row slot cycles through the three banks
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      slot_in      = slot_ff;
      if (csr_write) begin
         col_count_in = '0;
         row_count_in = '0;
         slot_in      = 2'd0;
      end else if (accept) begin
         if (at_last_col) begin
            col_count_in = '0;
            if (at_last_row) begin
               row_count_in = '0;
               slot_in      = 2'd0;
            end else begin
               row_count_in = row_count_ff + RW'(1);
               slot_in      = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
            end
         end else begin
            col_count_in = col_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         slot_ff      <= 2'd0;
         last_col_ff  <= LAST_COL_RST[CW-1:0];
         last_row_ff  <= LAST_ROW_RST[RW-1:0];
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         slot_ff      <= slot_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
      end
   end

   always_comb begin
      ld_flags.prev_row  = row_count_ff != '0;
      ld_flags.prev2_row = row_count_ff[RW-1:1] != '0;
      ld_flags.last_row  = at_last_row;
      ld_flags.prev_col  = col_count_ff != '0;
      ld_flags.prev2_col = col_count_ff[CW-1:1] != '0;
      ld_flags.last_col  = at_last_col;
   end

   dmsc_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .access  (accept),
      .wr_slot (slot_ff),
      .addr    (col_count_ff),
      .wr_data (req_raw_pixel),
      .rd_data (rd_data)
   );

   dmsc_window #(
      .CW (CW),
      .RW (RW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .ld_col    (col_count_ff),
      .ld_row    (row_count_ff),
      .ld_slot   (slot_ff),
      .ld_pixel  (req_raw_pixel),
      .ld_flags  (ld_flags),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .take      (req_ready),
      .res_valid (res_valid),
      .res_col   (res_col),
      .res_row   (res_row),
      .res       (res)
   );

   // Output register: load a new result whenever the old one is gone or leaving
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_col_ff <= res_col;
         rsp_row_ff <= res_row;
         rsp_res_ff <= res;
      end
   end

   // Coordinates go out masked to 11 bits
   assign col_ext = {11'd0, rsp_col_ff};
   assign row_ext = {11'd0, rsp_row_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_col    = col_ext[10:0];
   assign rsp_out_row    = row_ext[10:0];
   assign rsp_red        = rsp_res_ff.red;
   assign rsp_green      = rsp_res_ff.green;
   assign rsp_blue       = rsp_res_ff.blue;
   assign rsp_run_last   = rsp_res_ff.run_last;
   assign rsp_frame_done = rsp_res_ff.frame_done;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !res_valid)
      else $error("result produced while output register is held");

   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_ff.frame_done) |-> rsp_res_ff.run_last)
      else $error("frame end not on last result of its request");

   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      (col_count_ff <= last_col_ff) && (row_count_ff <= last_row_ff))
      else $error("raster position beyond frame");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && at_last_col && at_last_row) |=>
         (col_count_ff == '0) && (row_count_ff == '0) && (slot_ff == 2'd0))
      else $error("position did not wrap after bottom-right sample");
`endif

endmodule
